>>> sv/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants for the square-wave voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_VOICES_DEF = 16;
  localparam int MAX_BURST_DEF  = 64;

  // Slot field is 4 bits wide, so no more than this many slots are reachable
  localparam int SLOT_FIELD_LIMIT = 16;

  // Field widths
  localparam int FIELD_W  = 15;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 7;
  localparam int SLOTF_W  = 4;
  localparam int KIND_W   = 2;

  // Accumulator holds a signed sum of up to 16 unsigned 15-bit levels, each added or subtracted
  localparam int ACC_W = 20;

  localparam logic signed [ACC_W-1:0] SAMPLE_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -ACC_W'(32768);

  // Item kinds carried on the input tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // One voice table entry
  typedef struct packed {
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] level;
    logic [FIELD_W-1:0] counter;
  } voice_t;

endpackage

>>> sv/svm_voice_ram.sv
// ----------------------------------------------------------------------------
// svm_voice_ram
// Voice table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module svm_voice_ram
  import svm_pkg::*;
#(
  parameter int DEPTH  = SLOT_FIELD_LIMIT,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  voice_t            wdata,
  input  logic [ADDR_W-1:0] raddr,
  output voice_t            rdata
);

  voice_t mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/svm_mix_unit.sv
// ----------------------------------------------------------------------------
// svm_mix_unit
// Shared mixing unit: adds one voice's square-wave level to the running sum,
// advances that voice's phase counter, and saturates the sum to 16 bits.
// ----------------------------------------------------------------------------
module svm_mix_unit
  import svm_pkg::*;
(
  input  logic                       clk,
  input  logic                       clr,
  input  logic                       en,
  input  voice_t                     voice,
  output logic [FIELD_W-1:0]         counter_next,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] level_ext;
  logic [FIELD_W-1:0]      half;
  logic [FIELD_W:0]        ctr_inc;

  // Low half of the period contributes -level, high half +level
  always_comb begin
    half      = voice.period >> 1;
    level_ext = ACC_W'(voice.level);
    if (voice.counter < half) begin
      acc_next = acc - level_ext;
    end else begin
      acc_next = acc + level_ext;
    end
  end

  // Advance the phase and wrap at the period
  always_comb begin
    ctr_inc = {1'b0, voice.counter} + (FIELD_W+1)'(1);
    if (ctr_inc >= {1'b0, voice.period}) begin
      counter_next = '0;
    end else begin
      counter_next = ctr_inc[FIELD_W-1:0];
    end
  end

  // Hold the running sum
  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc_next;
    end
  end

  // Clamp to the signed 16-bit range
  always_comb begin
    if (acc > SAMPLE_MAX) begin
      sample = SAMPLE_W'(SAMPLE_MAX);
    end else if (acc < SAMPLE_MIN) begin
      sample = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sample = acc[SAMPLE_W-1:0];
    end
  end

endmodule

>>> sv/square_voice_mixer.sv
// ----------------------------------------------------------------------------
// square_voice_mixer
// Polyphonic square-wave mixer: a voice table with add and remove items, and
// tick items that produce bursts of saturated 16-bit mixed samples.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata                                   tuser / tlast
//  -------  ---  --------------------------------------  ----------------
//  s_*      in   count, wavelength, volume, phase, slot  tuser = kind
//  m_*      out  sample, given_slot, accepted            tlast = last
//
//  For each sample of a tick the one mix unit visits every usable slot (min
//  of MAX_VOICES and 16) through the voice table's single read port, then
//  the sequencer goes through a drain and an emit step. Add and remove pass
//  their own step and a response step; unknown kinds go straight to the
//  response step. Reset clears the active bits and the control state; table
//  entries are written by add before they are used. s_tready is high only while idle;
//  a held-off m_tready stalls the sequencer in its emit or response step.
//
module square_voice_mixer
  import svm_pkg::*;
#(
  parameter int MAX_VOICES = MAX_VOICES_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata, low bit up: sample_count[6:0], wavelength[14:0], volume[14:0],
  //                      start_phase[14:0], slot[3:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  // s_tuser: kind[1:0]
  input  logic [1:0]  s_tuser,
  // m_tdata, low bit up: sample[15:0], given_slot[3:0], accepted, 3 zero bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  localparam int SLOT_LIMIT = (MAX_VOICES < SLOT_FIELD_LIMIT) ? MAX_VOICES
                                                              : SLOT_FIELD_LIMIT;
  localparam int SLOT_W     = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;
  localparam int CNT_W      = $clog2(MAX_BURST + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_DRAIN,
    S_EMIT,
    S_ADD,
    S_REMOVE,
    S_RESP
  } state_t;

  state_t state;

  // Input fields
  logic [COUNT_W-1:0] in_count;
  logic [FIELD_W-1:0] in_wl;
  logic [FIELD_W-1:0] in_vol;
  logic [FIELD_W-1:0] in_ph;
  logic [SLOTF_W-1:0] in_slot;

  assign in_count = s_tdata[6:0];
  assign in_wl    = s_tdata[21:7];
  assign in_vol   = s_tdata[36:22];
  assign in_ph    = s_tdata[51:37];
  assign in_slot  = s_tdata[55:52];

  // Held item fields
  logic [FIELD_W-1:0] item_wl;
  logic [FIELD_W-1:0] item_vol;
  logic [FIELD_W-1:0] item_ph;
  logic [SLOTF_W-1:0] item_slot;

  // Sequencer registers
  logic [SLOT_LIMIT-1:0] active;
  logic [CNT_W-1:0]      remaining;
  logic [SLOT_W-1:0]     vidx;
  logic                  pipe_vld;
  logic [SLOT_W-1:0]     pipe_idx;
  logic                  resp_ok;
  logic [SLOTF_W-1:0]    resp_slot;

  // Output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic [SLOTF_W-1:0]         out_slot;
  logic                       out_ok;
  logic                       out_free;
  logic                       out_load;

  logic accept;
  logic [COUNT_W-1:0] count_clip;

  // Free-slot search and remove check
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              add_valid;
  logic              slot_in_range;
  logic [SLOT_W-1:0] rem_idx;

  // Table and mix unit hookup
  logic                       ram_we;
  logic [SLOT_W-1:0]          ram_waddr;
  voice_t                     ram_wdata;
  voice_t                     ram_rdata;
  logic                       mix_clr;
  logic                       mix_en;
  logic [FIELD_W-1:0]         ctr_next;
  logic signed [SAMPLE_W-1:0] mix_sample;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign out_load = out_free && ((state == S_EMIT) || (state == S_RESP));

  assign count_clip = (in_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : in_count;

  // Find the lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign add_valid     = (item_wl != '0) && (item_ph < item_wl);
  assign slot_in_range = ({1'b0, item_slot} < (SLOTF_W+1)'(SLOT_LIMIT));
  assign rem_idx       = slot_in_range ? item_slot[SLOT_W-1:0] : '0;

  // Write back the advanced counter, or store a new voice
  assign mix_en = pipe_vld && active[pipe_idx];

  always_comb begin
    if (state == S_ADD) begin
      ram_we            = add_valid && free_found;
      ram_waddr         = free_idx;
      ram_wdata.period  = item_wl;
      ram_wdata.level   = item_vol;
      ram_wdata.counter = item_ph;
    end else begin
      ram_we            = mix_en;
      ram_waddr         = pipe_idx;
      ram_wdata.period  = ram_rdata.period;
      ram_wdata.level   = ram_rdata.level;
      ram_wdata.counter = ctr_next;
    end
  end

  assign mix_clr = (accept && (kind_t'(s_tuser) == KIND_TICK))
                || ((state == S_EMIT) && out_free);

  svm_voice_ram #(
    .DEPTH  (SLOT_LIMIT),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (vidx),
    .rdata (ram_rdata)
  );

  svm_mix_unit u_mix (
    .clk          (clk),
    .clr          (mix_clr),
    .en           (mix_en),
    .voice        (ram_rdata),
    .counter_next (ctr_next),
    .sample       (mix_sample)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      remaining <= '0;
      vidx      <= '0;
      pipe_vld  <= 1'b0;
      pipe_idx  <= '0;
      resp_ok   <= 1'b0;
      resp_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new output transaction, or drop the current one once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      pipe_vld <= (state == S_MIX);

      case (state)
        S_IDLE: begin
          if (accept) begin
            item_wl   <= in_wl;
            item_vol  <= in_vol;
            item_ph   <= in_ph;
            item_slot <= in_slot;
            case (kind_t'(s_tuser))
              KIND_TICK: begin
                remaining <= CNT_W'(count_clip);
                vidx      <= '0;
                if (count_clip != '0) begin
                  state <= S_MIX;
                end
              end
              KIND_ADD: begin
                state <= S_ADD;
              end
              KIND_REMOVE: begin
                state <= S_REMOVE;
              end
              default: begin
                resp_ok   <= 1'b0;
                resp_slot <= '0;
                state     <= S_RESP;
              end
            endcase
          end
        end

        // Issue one table read per cycle; the mix unit works on each entry in the cycle after its read
        S_MIX: begin
          pipe_idx <= vidx;
          if (vidx == SLOT_W'(SLOT_LIMIT - 1)) begin
            state <= S_DRAIN;
          end else begin
            vidx <= vidx + SLOT_W'(1);
          end
        end

        S_DRAIN: begin
          state <= S_EMIT;
        end

        // Hand the finished sample to the output register
        S_EMIT: begin
          if (out_free) begin
            out_sample <= mix_sample;
            out_last   <= (remaining == CNT_W'(1));
            out_slot   <= '0;
            out_ok     <= 1'b1;
            vidx       <= '0;
            if (remaining == CNT_W'(1)) begin
              state <= S_IDLE;
            end else begin
              remaining <= remaining - CNT_W'(1);
              state     <= S_MIX;
            end
          end
        end

        S_ADD: begin
          if (add_valid && free_found) begin
            active[free_idx] <= 1'b1;
            resp_ok          <= 1'b1;
            resp_slot        <= SLOTF_W'(free_idx);
          end else begin
            resp_ok   <= 1'b0;
            resp_slot <= '0;
          end
          state <= S_RESP;
        end

        S_REMOVE: begin
          resp_slot <= '0;
          if (slot_in_range && active[rem_idx]) begin
            active[rem_idx] <= 1'b0;
            resp_ok         <= 1'b1;
          end else begin
            resp_ok <= 1'b0;
          end
          state <= S_RESP;
        end

        S_RESP: begin
          if (out_free) begin
            out_sample <= '0;
            out_last   <= 1'b1;
            out_slot   <= resp_slot;
            out_ok     <= resp_ok;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'b000, out_ok, out_slot, out_sample};

endmodule
